>>> design/g6ed_pkg.sv
// Shared types and constants for the graph6 edge decoder.
// No dependencies; imported by the front, queue, back and top-level modules.
`default_nettype none

package g6ed_pkg;

    // Byte ranges of the graph6 small-graph form
    localparam logic [7:0] BYTE_BIAS = 8'd63;   // subtracted from every byte
    localparam logic [7:0] HDR_MAX   = 8'd125;  // largest single-byte header
    localparam logic [7:0] DATA_MAX  = 8'd126;  // '~', largest data byte

    localparam int unsigned BITS_PER_BYTE = 6;

    // Result codes on the output channel
    typedef enum logic [2:0] {
        KIND_EDGE     = 3'd0,
        KIND_HDR_OK   = 3'd1,
        KIND_REC_OK   = 3'd2,
        KIND_BAD_HDR  = 3'd3,
        KIND_BAD_BYTE = 3'd4,
        KIND_SHORT    = 3'd5
    } kind_t;

    // Work handed from the front end to the back end
    typedef enum logic [1:0] {
        OP_HDR      = 2'd0,
        OP_BAD_HDR  = 2'd1,
        OP_DATA     = 2'd2,
        OP_BAD_BYTE = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [5:0]  value;   // vertex count (header) or six adjacency bits (data)
        logic        last;    // byte closes the record
    } op_t;

endpackage

`default_nettype wire

>>> design/g6ed_front.sv
// Front end: accepts record bytes, tracks the record phase, classifies each byte.
// Uses g6ed_pkg; feeds g6ed_queue.
`default_nettype none

module g6ed_front
    import g6ed_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] byte_value
    input  wire logic       s_tlast,   // last_byte
    input  wire logic       q_full,
    output logic            q_push,
    output op_t             q_op
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_DISCARD
    } phase_t;

    phase_t phase_reg, phase_next;

    logic       accept;
    logic       in_low_ok;
    logic       hdr_ok;
    logic       data_ok;
    logic [7:0] unbiased;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign in_low_ok = (s_tdata >= BYTE_BIAS);
    assign hdr_ok    = in_low_ok && (s_tdata <= HDR_MAX);
    assign data_ok   = in_low_ok && (s_tdata <= DATA_MAX);
    assign unbiased  = s_tdata - BYTE_BIAS;

    always_comb begin
        phase_next = phase_reg;
        q_push     = 1'b0;
        q_op.kind  = OP_DATA;
        q_op.value = unbiased[5:0];
        q_op.last  = s_tlast;
        if (accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    q_push     = 1'b1;
                    q_op.kind  = hdr_ok ? OP_HDR : OP_BAD_HDR;
                    phase_next = s_tlast ? PH_HEADER : (hdr_ok ? PH_DATA : PH_DISCARD);
                end
                PH_DATA: begin
                    q_push     = 1'b1;
                    q_op.kind  = data_ok ? OP_DATA : OP_BAD_BYTE;
                    phase_next = s_tlast ? PH_HEADER : (data_ok ? PH_DATA : PH_DISCARD);
                end
                default: begin
                    // discarding the rest of a failed record
                    phase_next = s_tlast ? PH_HEADER : PH_DISCARD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
        end else begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

>>> design/g6ed_queue.sv
// Short FIFO of decoded operations between the front and back ends.
// Uses g6ed_pkg for the operation type.
`default_nettype none

module g6ed_queue
    import g6ed_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  op_t       push_op,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output op_t       head_op
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    op_t           slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_op    = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_push_blocked_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (full && push && !pop) |=> full)
        else $error("queue left full state without a pop");

    a_pop_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CW'(1) && do_pop && !do_push) |=> !head_valid)
        else $error("queue not empty after popping its only entry");

endmodule

`default_nettype wire

>>> design/g6ed_back.sv
// Back end: walks the adjacency triangle and emits edge and status items.
// Uses g6ed_pkg; pops operations from g6ed_queue and drives the output register.
`default_nettype none

module g6ed_back
    import g6ed_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  q_valid,
    input  op_t        q_op,
    output logic       q_pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output kind_t      out_kind,
    output logic [5:0] out_low,
    output logic [5:0] out_high,
    output logic [5:0] out_count,
    output logic       out_end
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_STATUS
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  n_reg,     n_next;      // vertex total
    logic [10:0] tri_reg,   tri_next;    // triangle size n(n-1)/2
    logic [5:0]  col_reg,   col_next;
    logic [5:0]  row_reg,   row_next;
    logic [10:0] pos_reg,   pos_next;    // triangle bits consumed so far
    logic [5:0]  eff_reg,   eff_next;    // in-triangle bits still to walk, MSB first
    logic        last_reg,  last_next;
    logic [2:0]  cnt_reg,   cnt_next;

    logic        out_valid_reg, out_valid_next;
    kind_t       out_kind_reg,  out_kind_next;
    logic [5:0]  out_low_reg,   out_low_next;
    logic [5:0]  out_high_reg,  out_high_next;
    logic [5:0]  out_count_reg, out_count_next;
    logic        out_end_reg,   out_end_next;

    logic        out_free;
    logic [10:0] remain;
    logic [5:0]  in_tri_mask;
    logic [5:0]  n_dec;
    logic [11:0] tri_prod;
    logic        hdr_good;
    logic        emit;
    kind_t       e_kind;
    logic [5:0]  e_low, e_high;
    logic        e_end;

    assign out_free = !out_valid_reg || out_ready;
    assign remain   = tri_reg - pos_reg;
    assign hdr_good = (q_op.kind == OP_HDR);

    // Bit j of a data byte (MSB first) lies inside the triangle if j < remaining bits
    always_comb begin
        for (int j = 0; j < BITS_PER_BYTE; j++) begin
            in_tri_mask[BITS_PER_BYTE-1-j] = (remain > 11'(j));
        end
    end

    assign n_dec    = (n_next == '0) ? '0 : n_next - 6'd1;
    assign tri_prod = 12'(n_next) * 12'(n_dec);

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        tri_next   = tri_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pos_next   = pos_reg;
        eff_next   = eff_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        e_kind     = KIND_EDGE;
        e_low      = '0;
        e_high     = '0;
        e_end      = 1'b1;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_op.kind)
                        OP_DATA: begin
                            q_pop      = 1'b1;
                            eff_next   = q_op.value & in_tri_mask;
                            last_next  = q_op.last;
                            cnt_next   = '0;
                            state_next = ST_BITS;
                        end
                        OP_HDR, OP_BAD_HDR: begin
                            if (out_free) begin
                                q_pop      = 1'b1;
                                n_next     = hdr_good ? q_op.value : '0;
                                col_next   = 6'd1;
                                row_next   = '0;
                                pos_next   = '0;
                                emit       = 1'b1;
                                e_kind     = hdr_good ? KIND_HDR_OK : KIND_BAD_HDR;
                                e_end      = !(hdr_good && q_op.last);
                                state_next = (hdr_good && q_op.last) ? ST_STATUS : ST_IDLE;
                            end
                        end
                        OP_BAD_BYTE: begin
                            if (out_free) begin
                                q_pop  = 1'b1;
                                emit   = 1'b1;
                                e_kind = KIND_BAD_BYTE;
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_BITS: begin
                if (!eff_reg[5] || out_free) begin
                    if (eff_reg[5]) begin
                        emit   = 1'b1;
                        e_kind = KIND_EDGE;
                        e_low  = row_reg;
                        e_high = col_reg;
                        e_end  = !last_reg && (eff_reg[4:0] == '0);
                    end
                    if (col_reg < n_reg) begin
                        pos_next = pos_reg + 11'd1;
                        if (row_reg + 6'd1 >= col_reg) begin
                            row_next = '0;
                            col_next = col_reg + 6'd1;
                        end else begin
                            row_next = row_reg + 6'd1;
                        end
                    end
                    eff_next = {eff_reg[4:0], 1'b0};
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'(BITS_PER_BYTE - 1)) begin
                        state_next = last_reg ? ST_STATUS : ST_IDLE;
                    end
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = (col_reg >= n_reg) ? KIND_REC_OK : KIND_SHORT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        tri_next = (state_reg == ST_IDLE && q_pop && q_op.kind != OP_DATA
                    && q_op.kind != OP_BAD_BYTE) ? tri_prod[11:1] : tri_reg;

        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_low_next   = out_low_reg;
        out_high_next  = out_high_reg;
        out_count_next = out_count_reg;
        out_end_next   = out_end_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_kind_next  = e_kind;
            out_low_next   = e_low;
            out_high_next  = e_high;
            out_count_next = n_next;
            out_end_next   = e_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            tri_reg       <= '0;
            col_reg       <= 6'd1;
            row_reg       <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            tri_reg       <= tri_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        eff_reg       <= eff_next;
        last_reg      <= last_next;
        out_kind_reg  <= out_kind_next;
        out_low_reg   <= out_low_next;
        out_high_reg  <= out_high_next;
        out_count_reg <= out_count_next;
        out_end_reg   <= out_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_low   = out_low_reg;
    assign out_high  = out_high_reg;
    assign out_count = out_count_reg;
    assign out_end   = out_end_reg;

    a_row_below_col: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg < col_reg)
        else $error("triangle walk: row not below column");

    a_pos_in_triangle: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= tri_reg)
        else $error("triangle walk ran past the triangle");

    a_edge_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg == KIND_EDGE) |->
            (out_low_reg < out_high_reg && out_high_reg < out_count_reg))
        else $error("edge outside vertex range or misordered");

endmodule

`default_nettype wire

>>> design/graph6_edge_decoder_top.sv
// Top level of the graph6 edge decoder: front end, operation queue, back end.
// Uses g6ed_pkg, g6ed_front, g6ed_queue and g6ed_back.
`default_nettype none

// Decodes graph6 records (single-byte header form, up to 62 vertices) arriving
// one byte per item on the s_ stream; s_tlast marks the final byte of a record.
// Each record yields a header status item, one edge item per set adjacency bit
// (edge_low < edge_high), and a closing status item on the last byte; a bad
// header or a bad data byte reports once and the rest of the record is dropped
// silently. m_tlast marks the last item caused by an input byte.
// Timing: the front end takes one byte per cycle while the operation queue
// (QUEUE_DEPTH entries) has room. The back end handles a header or bad byte
// in its idle state; a data byte is taken from the queue, then walked one
// adjacency bit at a time, edge or not, and the closing status follows in its
// own state; bytes being discarded cost no back-end time. The back end takes no
// new byte from the queue until the triangle walk of a data byte is done.
// Results leave through a single output register: while a result waits on
// m_tready, the back end keeps stepping over bits that emit nothing but holds
// at the next item it has to emit.

module graph6_edge_decoder_top
    import g6ed_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic        s_tlast,   // last_byte
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [5:0] edge_low, [11:6] edge_high,
                                        // [17:12] vertex_count, [23:18] zero
    output logic [2:0]       m_tuser,   // [2:0] kind
    output logic             m_tlast    // run_end
);

    logic  q_full;
    logic  q_push;
    op_t   q_push_op;
    logic  q_pop;
    logic  q_valid;
    op_t   q_head;

    kind_t      res_kind;
    logic [5:0] res_low;
    logic [5:0] res_high;
    logic [5:0] res_count;

    g6ed_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_push_op)
    );

    g6ed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_op    (q_push_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (q_head)
    );

    g6ed_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_op      (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (res_kind),
        .out_low   (res_low),
        .out_high  (res_high),
        .out_count (res_count),
        .out_end   (m_tlast)
    );

    assign m_tuser = res_kind;
    assign m_tdata = {6'd0, res_count, res_high, res_low};

endmodule

`default_nettype wire

>>> sim/g6ed_checker.sv
// Result checker for the graph6 edge decoder: predicts results from accepted bytes
// and compares them with the result channel. Depends on g6ed_pkg.
module g6ed_checker
    import g6ed_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic [2:0]  m_tuser,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending,
    output int               results_seen
);

    typedef enum logic [1:0] {
        WAIT_HEADER = 2'd0,
        TAKE_DATA   = 2'd1,
        SKIP_REST   = 2'd2
    } rec_phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [5:0] lo;
        logic [5:0] hi;
        logic [5:0] nv;
        logic       run_end;
    } g6_result_t;

    g6_result_t edge_results_q[$];

    rec_phase_t rec_phase = WAIT_HEADER;
    logic [5:0] vtx_total = '0;
    logic [5:0] col_idx   = 6'd1;
    logic [5:0] row_idx   = '0;

    g6_result_t byte_results[8];
    int         byte_result_n = 0;
    int         mismatches    = 0;
    int         seen          = 0;

    task automatic emit(input kind_t k, input logic [5:0] lo, input logic [5:0] hi);
        byte_results[byte_result_n] = '{k, lo, hi, vtx_total, 1'b0};
        byte_result_n++;
    endtask

    task automatic close_record();
        if (col_idx >= vtx_total) begin
            emit(KIND_REC_OK, 6'd0, 6'd0);
        end else begin
            emit(KIND_SHORT, 6'd0, 6'd0);
        end
        rec_phase = WAIT_HEADER;
    endtask

    // Walk one byte through the upper triangle, collecting the results it causes.
    task automatic decode_byte(input logic [7:0] b, input logic lst);
        logic [5:0] adj_bits;
        byte_result_n = 0;
        case (rec_phase)
            WAIT_HEADER: begin
                col_idx = 6'd1;
                row_idx = 6'd0;
                if (b < BYTE_BIAS || b > HDR_MAX) begin
                    vtx_total = 6'd0;
                    emit(KIND_BAD_HDR, 6'd0, 6'd0);
                    if (lst) rec_phase = WAIT_HEADER;
                    else     rec_phase = SKIP_REST;
                end else begin
                    vtx_total = b[5:0] - BYTE_BIAS[5:0];
                    emit(KIND_HDR_OK, 6'd0, 6'd0);
                    rec_phase = TAKE_DATA;
                    if (lst) close_record();
                end
            end
            TAKE_DATA: begin
                if (b < BYTE_BIAS || b > DATA_MAX) begin
                    emit(KIND_BAD_BYTE, 6'd0, 6'd0);
                    if (lst) rec_phase = WAIT_HEADER;
                    else     rec_phase = SKIP_REST;
                end else begin
                    adj_bits = b[5:0] - BYTE_BIAS[5:0];
                    for (int s = 5; s >= 0; s--) begin
                        if (col_idx >= vtx_total) break;   // rest is padding
                        if (adj_bits[s]) emit(KIND_EDGE, row_idx, col_idx);
                        row_idx++;
                        if (row_idx >= col_idx) begin
                            row_idx = 6'd0;
                            col_idx++;
                        end
                    end
                    if (lst) close_record();
                end
            end
            default: begin
                if (lst) rec_phase = WAIT_HEADER;
            end
        endcase
        if (byte_result_n > 0) byte_results[byte_result_n - 1].run_end = 1'b1;
        for (int i = 0; i < byte_result_n; i++)
            edge_results_q = {edge_results_q, byte_results[i]};
    endtask

    always @(posedge aclk) begin
        g6_result_t want;
        if (!aresetn) begin
            rec_phase = WAIT_HEADER;
            vtx_total = 6'd0;
            col_idx   = 6'd1;
            row_idx   = 6'd0;
            edge_results_q.delete();
        end else begin
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                seen++;
                if (edge_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind=%0d tdata=%h last=%b",
                                 m_tuser, m_tdata, m_tlast);
                end else begin
                    want = edge_results_q.pop_front();
                    if (m_tuser !== want.kind || m_tdata[5:0] !== want.lo ||
                        m_tdata[11:6] !== want.hi || m_tdata[17:12] !== want.nv ||
                        m_tdata[23:18] !== 6'd0 || m_tlast !== want.run_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected kind=%0d lo=%0d hi=%0d n=%0d ",
                                      "last=%b, got kind=%0d lo=%0d hi=%0d n=%0d pad=%h ",
                                      "last=%b"},
                                     seen, want.kind, want.lo, want.hi, want.nv,
                                     want.run_end, m_tuser, m_tdata[5:0], m_tdata[11:6],
                                     m_tdata[17:12], m_tdata[23:18], m_tlast);
                    end
                end
            end
        end
        fail_count   <= mismatches;
        pending      <= edge_results_q.size();
        results_seen <= seen;
    end

endmodule

>>> sim/tb_graph6_edge_decoder_top.sv
// Testbench top for the graph6 edge decoder: clock, reset, byte stimulus,
// output back-pressure and the verdict. Needs g6ed_pkg, the decoder RTL and g6ed_checker.
module tb_graph6_edge_decoder_top;
    import g6ed_pkg::*;

    localparam int IDLE_MAX_BURST = 17;
    localparam int RANDOM_BYTES   = 95;    // random bytes after the directed part
    localparam int QUIET_FROM     = 75;    // no idling on either side after this
    localparam int HOLD_AT        = 40;    // bytes taken before the long output stall
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_AT       = 80;    // mid-run pause until all results are back
    localparam int TAIL_CYCLES    = 32;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;    // [7:0] byte_value
    logic        s_tlast  = 1'b0;    // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [5:0] edge_low, [11:6] edge_high, [17:12] vertex_count
    logic [2:0]  m_tuser;            // [2:0] kind
    logic        m_tlast;            // run_end

    int fail_count;
    int pending;
    int results_seen;

    // bookkeeping for stimulus, idling and the watchdog
    int bytes_sent   = 0;    // counted by the sender after each handshake
    int bytes_taken  = 0;    // counted at the clock edge
    int records_sent = 0;
    int stall_cycles = 0;
    bit tx_idle_en   = 1'b1;
    bit rx_idle_en   = 1'b1;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    graph6_edge_decoder_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    g6ed_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // Watchdog: any cycle without a handshake on either side counts toward the limit.
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) bytes_taken <= bytes_taken + 1;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     stall_cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off partway through so the
    // decoder's queue fills up and it has to back-pressure the sender.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!hold_done && bytes_taken >= HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, IDLE_MAX_BURST)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // One byte, optionally after an idle burst; returns after the edge that takes it.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, IDLE_MAX_BURST)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (lst) records_sent++;
    endtask

    // Stop offering and wait until every predicted result has come back.
    // The first edge lets the checker's count catch up with the last byte taken.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Mostly well-formed records with random adjacency bytes; some short, some
    // with a padding byte too many, some with a bad header or a stray bad byte.
    task automatic send_random_record();
        int         n;
        int         need;
        int         nbytes;
        int         shape;
        logic [7:0] b;
        shape = $urandom_range(0, 99);
        if (shape < 8) begin
            // broken header, then whatever follows is discarded
            if ($urandom_range(0, 1) == 1) b = 8'($urandom_range(0, 62));
            else                          b = 8'($urandom_range(126, 255));
            nbytes = $urandom_range(0, 3);
            send_byte(b, nbytes == 0);
            for (int i = 0; i < nbytes; i++) send_byte(8'($urandom_range(0, 255)), i == nbytes - 1);
        end else begin
            if ($urandom_range(0, 9) == 0) n = $urandom_range(11, 62);
            else                           n = $urandom_range(0, 10);
            need = (n * (n - 1) / 2 + 5) / 6;
            if (n > 10) begin
                nbytes = $urandom_range(1, 6);          // big graphs end short
            end else begin
                nbytes = need;
                if (shape < 16)                   nbytes = need + 1;   // padding byte
                else if (shape < 24 && need > 0) nbytes = need - 1;   // short record
            end
            send_byte(8'(63 + n), nbytes == 0);
            for (int i = 0; i < nbytes; i++) begin
                if ($urandom_range(0, 29) == 0) b = 8'($urandom_range(0, 255));
                else                            b = 8'($urandom_range(63, 126));
                send_byte(b, i == nbytes - 1);
            end
        end
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: header-only records for n = 0, 1, 2
        send_byte(8'd63, 1'b1);
        send_byte(8'd64, 1'b1);
        send_byte(8'd65, 1'b1);
        // bad headers: below range, the unsupported '~' form with a discarded tail,
        // and the byte extremes
        send_byte(8'd62, 1'b1);
        send_byte(8'd126, 1'b0);
        send_byte(8'd65, 1'b0);
        send_byte(8'd63, 1'b1);
        send_byte(8'd255, 1'b1);
        send_byte(8'd0, 1'b1);
        // largest graph: a full byte of edges, then an empty byte, ends short
        send_byte(8'd125, 1'b0);
        send_byte(8'd126, 1'b0);
        send_byte(8'd63, 1'b1);
        // n = 4 with the header as last byte, then exactly one full byte
        send_byte(8'd67, 1'b1);
        send_byte(8'd67, 1'b0);
        send_byte(8'd126, 1'b1);
        // n = 4 with a padding byte after the triangle is complete
        send_byte(8'd67, 1'b0);
        send_byte(8'd126, 1'b0);
        send_byte(8'd100, 1'b1);
        // bad data byte mid-record, rest discarded
        send_byte(8'd66, 1'b0);
        send_byte(8'd62, 1'b0);
        send_byte(8'd200, 1'b1);
        // bad data byte on the last byte
        send_byte(8'd66, 1'b0);
        send_byte(8'd127, 1'b1);
        // n = 3, partial bit pattern, padding bits ignored
        send_byte(8'd66, 1'b0);
        send_byte(8'd103, 1'b1);
        wait_for_results();

        // random part
        while (bytes_sent < 25 + RANDOM_BYTES) begin
            if (!paused && bytes_sent >= 25 + DRAIN_AT - 40) begin
                wait_for_results();
                paused = 1'b1;
            end
            if (bytes_sent >= 25 + QUIET_FROM) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            send_random_record();
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d bytes in %0d records, %0d results checked,", bytes_sent,
                 records_sent, results_seen);
        $display("with idle bursts on both sides and a %0d-cycle output hold-off", HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> graph6_edge_decoder_top.f
design/g6ed_pkg.sv
design/g6ed_front.sv
design/g6ed_queue.sv
design/g6ed_back.sv
design/graph6_edge_decoder_top.sv
sim/g6ed_checker.sv
sim/tb_graph6_edge_decoder_top.sv
